// ===== hdl/jsfx_pkg.sv =====
// ----------------------------------------------------------------------------
// jsfx_pkg
// Types, character codes and sizing constants shared by the JSON string
// field extractor.
// ----------------------------------------------------------------------------
package jsfx_pkg;

    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam int KEY_LEN_W         = 5;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_DONE     = 2'd1,
        ST_FAIL     = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_COLON  = 3'd1,
        PH_SPACE  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_ESCAPE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [63:0]          key_high;
        logic [63:0]          key_low;
        logic [KEY_LEN_W-1:0] key_length;
    } key_cfg_t;

    typedef struct packed {
        logic step;
        logic rearm;
    } win_ctl_t;

    typedef struct packed {
        logic       produce;
        logic [7:0] value_byte;
        logic       has_byte;
        status_t    status;
        logic       last;
    } res_t;

endpackage

// ===== hdl/jsfx_ifs.sv =====
// ----------------------------------------------------------------------------
// jsfx interfaces
// Valid/ready channels for document bytes, results and configuration writes.
// ----------------------------------------------------------------------------
interface jsfx_doc_if;
    logic       valid;
    logic       ready;
    logic [7:0] doc_byte;
    logic       doc_last;

    modport source (output valid, output doc_byte, output doc_last, input ready);
    modport sink   (input valid, input doc_byte, input doc_last, output ready);
endinterface

interface jsfx_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       result_last;

    modport source (output valid, output value_byte, output has_byte, output status,
                    output result_last, input ready);
    modport sink   (input valid, input value_byte, input has_byte, input status,
                    input result_last, output ready);
endinterface

interface jsfx_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/jsfx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jsfx_cfg_regs
// Key configuration registers written over the configuration channel.
// ----------------------------------------------------------------------------
module jsfx_cfg_regs
    import jsfx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output key_cfg_t               key
);

    key_cfg_t key_reg;
    key_cfg_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY_LOW:  key_next.key_low    = wr_data;
                REG_KEY_HIGH: key_next.key_high   = wr_data;
                REG_KEY_LEN:  key_next.key_length = wr_data[KEY_LEN_W-1:0];
                default:      key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// ===== hdl/jsfx_key_window.sv =====
// ----------------------------------------------------------------------------
// jsfx_key_window
// Sliding window of the latest document bytes and the quote-key-quote compare.
// ----------------------------------------------------------------------------
module jsfx_key_window
    import jsfx_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  key_cfg_t   key,
    input  win_ctl_t   ctl,
    input  logic [7:0] data,
    output logic       match
);

    localparam int WIN_DEPTH = MAX_KEY_BYTES + 2;
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

    logic [7:0]           win_reg [WIN_DEPTH];
    logic [7:0]           shifted [WIN_DEPTH];
    logic [CNT_W-1:0]     seen_reg;
    logic [CNT_W-1:0]     seen_next;
    logic [KEY_LEN_W-1:0] klen;
    logic [127:0]         key_bits;

    assign key_bits = {key.key_high, key.key_low};
    assign klen = (key.key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                  KEY_LEN_W'(MAX_KEY_BYTES) : key.key_length;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            shifted[i] = win_reg[i+1];
        end
        shifted[WIN_DEPTH-1] = data;
    end

    assign seen_next = (seen_reg == CNT_W'(WIN_DEPTH)) ? seen_reg : seen_reg + 1'b1;

    // The window is judged as it will stand once the current byte is shifted in.
    always_comb
    begin
        int kl;
        int base;
        kl    = int'(klen);
        base  = WIN_DEPTH - 2 - kl;
        match = (int'(seen_next) >= kl + 2) &&
                (shifted[IDX_W'(base)] == CH_QUOTE) &&
                (shifted[WIN_DEPTH-1] == CH_QUOTE);
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (i < kl)
            begin
                if (shifted[IDX_W'(base + 1 + i)] != key_bits[8*i +: 8])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctl.rearm)
        begin
            seen_reg <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctl.step)
        begin
            seen_reg <= seen_next;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= shifted[i];
            end
        end
    end

endmodule

// ===== hdl/jsfx_parser.sv =====
// ----------------------------------------------------------------------------
// jsfx_parser
// Phase state machine: colon and whitespace skipping, value decode, status.
// ----------------------------------------------------------------------------
module jsfx_parser
    import jsfx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data,
    input  logic       last,
    input  logic       match,
    output res_t       res,
    output win_ctl_t   win_ctl
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       finished_reg;
    logic       finished_next;
    status_t    ev;
    logic       emit;
    logic [7:0] emit_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        finished_next = finished_reg;
        ev            = ST_PROGRESS;
        emit          = 1'b0;
        emit_byte     = '0;

        if (!finished_reg)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (match)
                    begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (data == CH_COLON)
                    begin
                        phase_next = PH_SPACE;
                    end
                end
                PH_SPACE:
                begin
                    case (data) inside
                        CH_SPACE, CH_TAB, CH_CR, CH_LF: phase_next = PH_SPACE;
                        CH_QUOTE:                       phase_next = PH_VALUE;
                        default:                        ev = ST_FAIL;
                    endcase
                end
                PH_VALUE:
                begin
                    if (data == CH_QUOTE)
                    begin
                        ev = ST_DONE;
                    end
                    else if (data == CH_BSLASH)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = data;
                    end
                end
                PH_ESCAPE:
                begin
                    phase_next = PH_VALUE;
                    emit       = 1'b1;
                    case (data)
                        CH_QUOTE:  emit_byte = CH_QUOTE;
                        CH_BSLASH: emit_byte = CH_BSLASH;
                        CH_SLASH:  emit_byte = CH_SLASH;
                        CH_LC_B:   emit_byte = CH_BS;
                        CH_LC_F:   emit_byte = CH_FF;
                        CH_LC_N:   emit_byte = CH_LF;
                        CH_LC_R:   emit_byte = CH_CR;
                        CH_LC_T:   emit_byte = CH_TAB;
                        default:
                        begin
                            emit = 1'b0;
                            ev   = ST_FAIL;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end

        // The document ending before the value is complete is a failure.
        if (!finished_reg && (ev == ST_PROGRESS) && last)
        begin
            ev = ST_FAIL;
        end

        if (ev != ST_PROGRESS)
        begin
            finished_next = 1'b1;
        end
        if (last)
        begin
            phase_next    = PH_SEARCH;
            finished_next = 1'b0;
        end
        if (!fire)
        begin
            phase_next    = phase_reg;
            finished_next = finished_reg;
        end

        res.last       = (ev != ST_PROGRESS);
        res.status     = ev;
        res.has_byte   = emit && (ev == ST_PROGRESS);
        res.value_byte = res.has_byte ? emit_byte : 8'h00;
        res.produce    = res.last || res.has_byte;

        win_ctl.step  = fire && !finished_reg && (phase_reg == PH_SEARCH);
        win_ctl.rearm = fire && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== hdl/json_string_field_extractor.sv =====
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Extracts the string value of a configured key from a streamed JSON document.
// ----------------------------------------------------------------------------
// Document bytes arrive on the doc channel, one request per byte, with
// doc_last marking the final byte. Results leave on the result channel: a
// decoded value byte (has_byte set, status 0) or a final status with
// result_last set (1 complete, 2 not found or malformed). Bytes that cause no
// result, such as bytes before the key, produce no request on the output.
// The key is written over the cfg channel (index 0 low key bytes, 1 high key
// bytes, 2 key length); the user must write it only while no document is in
// flight, which the block does not enforce; cfg is always ready. A byte is
// registered on acceptance and decoded into the result register, which then
// offers the result. One byte is accepted every cycle while the receiver
// keeps up; the single decode stage between the input and result registers
// sets that rate. When the receiver stalls, the result register holds its
// request; a byte that needs the result register then waits in the input
// register and doc ready drops, while bytes producing no result still pass.
// Reset clears the key registers, the byte window and the parsing state; the
// last byte of each document re-arms the parser and keeps the key.
// ----------------------------------------------------------------------------
module json_string_field_extractor
    import jsfx_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    jsfx_doc_if.sink      doc,
    jsfx_res_if.source    result,
    jsfx_cfg_if.sink      cfg
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_res_reg;
    res_t       res;
    win_ctl_t   win_ctl;
    key_cfg_t   key;
    logic       match;
    logic       out_free;
    logic       fire;
    logic       load;

    assign cfg.ready = 1'b1;

    jsfx_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .key      (key)
    );

    jsfx_key_window #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_key_window (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .ctl   (win_ctl),
        .data  (in_byte_reg),
        .match (match)
    );

    jsfx_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .data    (in_byte_reg),
        .last    (in_last_reg),
        .match   (match),
        .res     (res),
        .win_ctl (win_ctl)
    );

    assign out_free  = !out_valid_reg || result.ready;
    assign fire      = in_valid_reg && (!res.produce || out_free);
    assign load      = fire && res.produce;
    assign doc.ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (doc.valid && doc.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (doc.valid && doc.ready)
        begin
            in_byte_reg <= doc.doc_byte;
            in_last_reg <= doc.doc_last;
        end
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.value_byte  = out_res_reg.value_byte;
    assign result.has_byte    = out_res_reg.has_byte;
    assign result.status      = out_res_reg.status;
    assign result.result_last = out_res_reg.last;

endmodule

// ===== hdl/jsfx_checker.sv =====
// ----------------------------------------------------------------------------
// jsfx_checker
// Port-level checks on the extractor's document and result channels.
// ----------------------------------------------------------------------------
module jsfx_checker
    import jsfx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       doc_valid,
    input logic       doc_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] value_byte,
    input logic       has_byte,
    input logic [1:0] status,
    input logic       result_last
);

    // A stalled result request is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(value_byte) && $stable(has_byte) && $stable(status) &&
            $stable(result_last))
    else $error("result payload changed while stalled");

    // A fresh result follows a byte accepted on the document channel before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(doc_valid && doc_ready, 2))
    else $error("result appeared without a matching document byte");

    // Value bytes carry status in progress; final statuses carry no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (has_byte && status == ST_PROGRESS && !result_last) ||
                      (!has_byte && result_last &&
                       (status == ST_DONE || status == ST_FAIL)))
    else $error("malformed result item");

endmodule

bind json_string_field_extractor jsfx_checker u_jsfx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .doc_valid   (doc.valid),
    .doc_ready   (doc.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .value_byte  (result.value_byte),
    .has_byte    (result.has_byte),
    .status      (result.status),
    .result_last (result.result_last)
);

// ===== bench/jsfx_checker.sv =====
// ----------------------------------------------------------------------------
// jsfx_result_checker
// Watches the document, result and key-write channels of the JSON string
// field extractor. It decodes every accepted document byte the way the block
// should and checks each result request against the oldest outstanding one.
// ----------------------------------------------------------------------------
module jsfx_result_checker
    import jsfx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    jsfx_doc_if    doc,
    jsfx_res_if    result,
    jsfx_cfg_if    cfg,
    output int     fails,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = MAX_KEY_BYTES_DEF + 2;

    typedef struct {
        logic [7:0] value_byte;
        logic       has_byte;
        status_t    status;
        logic       result_last;
    } field_result_t;

    field_result_t        expected_results[$];

    logic [63:0]          key_low;
    logic [63:0]          key_high;
    logic [KEY_LEN_W-1:0] key_length;

    phase_t               parse_phase;
    logic [7:0]           recent_bytes[WINDOW_DEPTH];
    int                   recent_count;
    logic                 status_given;

    function automatic void rearm_parser();
        parse_phase = PH_SEARCH;
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        recent_count = 0;
        status_given = 1'b0;
    endfunction

    // True when the newest bytes are a quote, the key and a quote.
    function automatic logic quoted_key_seen();
        int         klen;
        int         span;
        int         base;
        logic [7:0] kb;
        klen = (key_length > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : int'(key_length);
        span = klen + 2;
        base = WINDOW_DEPTH - span;
        if (recent_count < span)
            return 1'b0;
        if (recent_bytes[base] != CH_QUOTE || recent_bytes[WINDOW_DEPTH-1] != CH_QUOTE)
            return 1'b0;
        for (int i = 0; i < klen; i++)
        begin
            kb = (i < 8) ? key_low[8*i +: 8] : key_high[8*(i-8) +: 8];
            if (recent_bytes[base+1+i] != kb)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the parser by one document byte and queues what it should give.
    function automatic void decode_doc_byte(input logic [7:0] c, input logic last);
        status_t       outcome;
        logic          emit;
        logic [7:0]    emitted;
        field_result_t res;
        outcome = ST_PROGRESS;
        emit    = 1'b0;
        emitted = 8'h00;
        if (!status_given)
        begin
            case (parse_phase)
                PH_SEARCH:
                begin
                    for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                        recent_bytes[i] = recent_bytes[i+1];
                    recent_bytes[WINDOW_DEPTH-1] = c;
                    if (recent_count < WINDOW_DEPTH)
                        recent_count++;
                    if (quoted_key_seen())
                        parse_phase = PH_COLON;
                end
                PH_COLON:
                begin
                    if (c == CH_COLON)
                        parse_phase = PH_SPACE;
                end
                PH_SPACE:
                begin
                    if (c == CH_QUOTE)
                        parse_phase = PH_VALUE;
                    else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF)
                        outcome = ST_FAIL;
                end
                PH_VALUE:
                begin
                    if (c == CH_QUOTE)
                        outcome = ST_DONE;
                    else if (c == CH_BSLASH)
                        parse_phase = PH_ESCAPE;
                    else
                    begin
                        emit    = 1'b1;
                        emitted = c;
                    end
                end
                default:
                begin
                    parse_phase = PH_VALUE;
                    emit        = 1'b1;
                    case (c)
                        CH_QUOTE:  emitted = CH_QUOTE;
                        CH_BSLASH: emitted = CH_BSLASH;
                        CH_SLASH:  emitted = CH_SLASH;
                        CH_LC_B:   emitted = CH_BS;
                        CH_LC_F:   emitted = CH_FF;
                        CH_LC_N:   emitted = CH_LF;
                        CH_LC_R:   emitted = CH_CR;
                        CH_LC_T:   emitted = CH_TAB;
                        default:
                        begin
                            emit    = 1'b0;
                            outcome = ST_FAIL;
                        end
                    endcase
                end
            endcase
            // The document ending before the value closes is a failure, and
            // a value byte arriving on the last byte is dropped in its favour.
            if (outcome == ST_PROGRESS && last)
                outcome = ST_FAIL;
        end

        if (outcome != ST_PROGRESS)
        begin
            res = '{8'h00, 1'b0, outcome, 1'b1};
            expected_results.insert(expected_results.size(), res);
            status_given = 1'b1;
        end
        else if (emit)
        begin
            res = '{emitted, 1'b1, ST_PROGRESS, 1'b0};
            expected_results.insert(expected_results.size(), res);
        end

        if (last)
            rearm_parser();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        field_result_t want;
        if (!rst_n)
        begin
            key_low    = '0;
            key_high   = '0;
            key_length = '0;
            rearm_parser();
            expected_results.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KEY_LOW:  key_low    = cfg.data;
                    REG_KEY_HIGH: key_high   = cfg.data;
                    REG_KEY_LEN:  key_length = cfg.data[KEY_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (doc.valid && doc.ready)
                decode_doc_byte(doc.doc_byte, doc.doc_last);

            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error(
                        "unexpected result: value_byte %02h has_byte %0d status %0d last %0d",
                        result.value_byte, result.has_byte, result.status,
                        result.result_last);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.value_byte !== want.value_byte)
                    begin
                        $error("value_byte: expected %02h, got %02h",
                               want.value_byte, result.value_byte);
                        fails++;
                    end
                    if (result.has_byte !== want.has_byte)
                    begin
                        $error("has_byte: expected %0d, got %0d",
                               want.has_byte, result.has_byte);
                        fails++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, result.status);
                        fails++;
                    end
                    if (result.result_last !== want.result_last)
                    begin
                        $error("result_last: expected %0d, got %0d",
                               want.result_last, result.result_last);
                        fails++;
                    end
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb_json_string_field_extractor.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_field_extractor
// Streams directed and random JSON-like documents through the extractor
// under several key settings, with random gaps on the document side and
// random stalls on the result side; a checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_json_string_field_extractor;
    import jsfx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_STEP = 130;
    localparam int SETTINGS_COUNT = 7;
    localparam int DRAIN_CYCLES   = 8;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [7:0] BLANK_CODES[4]  = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    localparam logic [7:0] ESCAPE_CODES[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                               CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

    typedef logic [7:0] doc_bytes_t[$];

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 calm;
    int                   cycles;
    int                   bytes_sent;
    int                   chk_fails;
    int                   chk_pending;

    logic [63:0]          key_lo;
    logic [63:0]          key_hi;
    logic [KEY_LEN_W-1:0] key_len;

    jsfx_doc_if doc_ch();
    jsfx_res_if res_ch();
    jsfx_cfg_if cfg_ch();

    json_string_field_extractor dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .doc    (doc_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    jsfx_result_checker checker_i
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .doc     (doc_ch),
        .result  (res_ch),
        .cfg     (cfg_ch),
        .fails   (chk_fails),
        .pending (chk_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 29);

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic put_doc_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            doc_ch.valid <= 1'b0;
            @(negedge clk);
        end
        doc_ch.valid    <= 1'b1;
        doc_ch.doc_byte <= b;
        doc_ch.doc_last <= last;
        @(posedge clk);
        while (!doc_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_document(input doc_bytes_t bytes);
        foreach (bytes[i])
            put_doc_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Holds off until every outstanding result has come back and any byte
    // still in the pipeline that gives no result has drained.
    task automatic settle();
        doc_ch.valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly a well-formed key and value with random content; the rest are
    // missing colons, junk before the value, bad escapes, cut-off values and
    // plain noise.
    task automatic build_document(output doc_bytes_t q);
        int         shape;
        int         klen;
        int         n;
        logic [7:0] c;
        q = {};
        shape = $urandom_range(0, 99);
        klen  = (key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : int'(key_len);
        repeat ($urandom_range(0, 4)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        if (shape < 82)
        begin
            q.insert(q.size(), CH_QUOTE);
            for (int i = 0; i < klen; i++)
                q.insert(q.size(), (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8]);
            q.insert(q.size(), CH_QUOTE);
            repeat ($urandom_range(0, 2))
                q.insert(q.size(), BLANK_CODES[$urandom_range(0, 3)]);
            if (shape >= 3)
                q.insert(q.size(), CH_COLON);
            repeat ($urandom_range(0, 3))
                q.insert(q.size(), BLANK_CODES[$urandom_range(0, 3)]);
            if (shape >= 3 && shape <= 8)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c inside {CH_QUOTE, CH_SPACE, CH_TAB, CH_CR, CH_LF});
                q.insert(q.size(), c);
            end
            q.insert(q.size(), CH_QUOTE);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    q.insert(q.size(), CH_BSLASH);
                    q.insert(q.size(), ESCAPE_CODES[$urandom_range(0, 7)]);
                end
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_QUOTE || c == CH_BSLASH);
                    q.insert(q.size(), c);
                end
            end
            if (shape >= 9 && shape <= 16)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                 CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T});
                q.insert(q.size(), CH_BSLASH);
                q.insert(q.size(), c);
            end
            if (!(shape >= 17 && shape <= 24))
                q.insert(q.size(), CH_QUOTE);
            repeat ($urandom_range(0, 3)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                q.insert(q.size(), ($urandom_range(0, 3) == 0) ? CH_QUOTE
                                                               : 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        doc_bytes_t   docq;
        int           start_count;
        logic [63:0]  len_word;
        rst_n           = 1'b0;
        calm            = 1'b0;
        cycles          = 0;
        bytes_sent      = 0;
        key_lo          = '0;
        key_hi          = '0;
        key_len         = '0;
        doc_ch.valid    = 1'b0;
        doc_ch.doc_byte = 8'h00;
        doc_ch.doc_last = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_KEY_LOW;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int step = 0; step < SETTINGS_COUNT; step++)
        begin
            settle();
            // One whole setting runs without gaps or stalls.
            calm <= (step == 2);
            len_word = {$urandom, $urandom};
            case (step)
                1:
                begin
                    key_lo  = {$urandom, $urandom};
                    key_hi  = {$urandom, $urandom};
                    key_len = 5'd16;
                end
                2:
                begin
                    key_lo  = '0;
                    key_hi  = '1;
                    key_len = 5'd31;
                end
                3:
                begin
                    key_lo  = {$urandom, $urandom};
                    key_hi  = {$urandom, $urandom};
                    key_len = 5'd1;
                end
                4:
                begin
                    key_lo  = '0;
                    key_hi  = {$urandom, $urandom};
                    key_len = 5'd8;
                end
                5:
                begin
                    key_lo  = {$urandom, $urandom};
                    key_hi  = {$urandom, $urandom};
                    key_len = 5'($urandom_range(2, 15));
                end
                6:
                begin
                    key_lo  = {$urandom, $urandom};
                    key_hi  = '0;
                    key_len = 5'd0;
                end
                default: ;
            endcase
            if (step != 0)
            begin
                len_word[KEY_LEN_W-1:0] = key_len;
                write_reg(REG_KEY_LOW, key_lo);
                write_reg(REG_KEY_HIGH, key_hi);
                write_reg(REG_KEY_LEN, len_word);
            end
            if (step == 5)
                write_reg(REG_SPARE, {$urandom, $urandom});

            if (step == 0)
            begin
                // Empty key after reset: whitespace, every escape, then the
                // success status followed by an ignored trailing byte.
                docq = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_SPACE, CH_TAB, CH_QUOTE,
                         CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_SLASH,
                         CH_BSLASH, CH_LC_B, CH_BSLASH, CH_LC_F, CH_BSLASH, CH_LC_N,
                         CH_BSLASH, CH_LC_R, CH_BSLASH, CH_LC_T, CH_QUOTE, 8'hFF};
                send_document(docq);
                // A non-quote after the colon fails at once.
                docq = '{CH_QUOTE, CH_QUOTE, CH_COLON, 8'h00, 8'h78};
                send_document(docq);
            end

            start_count = bytes_sent;
            while (bytes_sent - start_count < ITEMS_PER_STEP)
            begin
                build_document(docq);
                send_document(docq);
            end
        end

        settle();
        if (chk_fails == 0 && chk_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== json_string_field_extractor.f =====
hdl/jsfx_pkg.sv
hdl/jsfx_ifs.sv
hdl/jsfx_cfg_regs.sv
hdl/jsfx_key_window.sv
hdl/jsfx_parser.sv
hdl/json_string_field_extractor.sv
hdl/jsfx_checker.sv
bench/jsfx_checker.sv
bench/tb_json_string_field_extractor.sv
